// File: sv/s2cal_pkg.sv
// Shared constants, width helpers and the month start table for the
// epoch seconds to calendar converter. No dependencies.
`default_nettype none

package s2cal_pkg;

  localparam int unsigned SECONDS_WIDTH_DEF = 48;

  // Quotient bits resolved by each stage of the constant dividers.
  localparam int unsigned DIV_STEP = 4;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned SOD_W        = 17;
  localparam int unsigned ERA_DAYS     = 146097;
  localparam int unsigned DOE_W        = 18;
  // Days from 0000-03-01 to 1970-01-01.
  localparam int unsigned EPOCH_SHIFT  = 719468;
  localparam int unsigned YEAR_W       = 24;
  localparam int unsigned YEAR_BASE    = 1900;
  localparam int unsigned CAL_STAGES   = 6;

  // Width of the shifted day count that feeds the era divider.
  function automatic int unsigned tmp_width(int unsigned sw);
    return (sw - 16 >= 21) ? sw - 15 : 22;
  endfunction

  // Pipeline stages of a constant divider for a signed dividend.
  function automatic int unsigned div_stages(int unsigned dw);
    return (dw - 1 + DIV_STEP - 1) / DIV_STEP;
  endfunction

  // Clock edges from the accepting edge to the edge that takes the result.
  function automatic int unsigned pipe_latency(int unsigned sw);
    return div_stages(sw) + 1 + 1 + div_stages(tmp_width(sw)) + 1 + CAL_STAGES;
  endfunction

  // First day of each March-based month, counted from March 1.
  function automatic logic [8:0] month_start(logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: sv/s2cal_div.sv
// Pipelined floor division of a signed value by a constant, a few
// quotient bits per stage, with a side payload. Uses s2cal_pkg.
`default_nettype none

module s2cal_div
  import s2cal_pkg::*;
#(
  parameter int unsigned DIVIDEND_W = 48,
  parameter int unsigned DIVISOR    = 86400,
  parameter int unsigned REM_W      = 17,
  parameter int unsigned SIDE_W     = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [DIVIDEND_W-1:0] in_dividend,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_valid,
  output logic [DIVIDEND_W-1:0]      out_quotient,
  output logic [REM_W-1:0]           out_remainder,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int unsigned MAG_W = DIVIDEND_W - 1;
  localparam int unsigned NSTG  = div_stages(DIVIDEND_W);
  localparam int unsigned PAD_W = NSTG * DIV_STEP;
  localparam logic [REM_W:0]   DIV_C  = (REM_W + 1)'(DIVISOR);
  localparam logic [REM_W-1:0] DIV_M1 = REM_W'(DIVISOR - 1);

  typedef struct packed {
    logic [PAD_W-1:0] bits;
    logic [REM_W-1:0] rem;
  } part_t;

  // Restoring division steps: remaining dividend bits shift out at the top
  // while quotient bits shift in at the bottom.
  function automatic part_t div_steps(part_t a);
    part_t          o;
    logic [REM_W:0] p;
    o = a;
    for (int k = 0; k < DIV_STEP; k++) begin
      p      = {o.rem, o.bits[PAD_W-1]};
      o.bits = {o.bits[PAD_W-2:0], 1'b0};
      if (p >= DIV_C) begin
        p         = p - DIV_C;
        o.bits[0] = 1'b1;
      end
      o.rem = p[REM_W-1:0];
    end
    return o;
  endfunction

  logic [NSTG-1:0]   vld_r;
  logic [NSTG-1:0]   neg_r;
  part_t             part_r   [NSTG];
  part_t             part_nxt [NSTG];
  logic [SIDE_W-1:0] side_r   [NSTG];

  logic [MAG_W-1:0]      mag;
  part_t                 seed;
  logic [MAG_W-1:0]      quo_mag;
  logic [DIVIDEND_W-1:0] quo_nxt;
  logic [REM_W-1:0]      rem_nxt;
  logic                  oval_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [REM_W-1:0]      rem_r;
  logic [SIDE_W-1:0]     oside_r;

  // A negative dividend t is divided as ~t = -t-1, which is never negative;
  // the floored result is then ~q with remainder DIVISOR-1-r.
  assign mag = in_dividend[MAG_W] ? ~in_dividend[MAG_W-1:0] : in_dividend[MAG_W-1:0];

  always_comb begin
    seed.bits   = PAD_W'(mag);
    seed.rem    = '0;
    part_nxt[0] = div_steps(seed);
    for (int s = 1; s < NSTG; s++) begin
      part_nxt[s] = div_steps(part_r[s-1]);
    end
  end

  assign quo_mag = part_r[NSTG-1].bits[MAG_W-1:0];
  assign quo_nxt = neg_r[NSTG-1] ? ~{1'b0, quo_mag} : {1'b0, quo_mag};
  assign rem_nxt = neg_r[NSTG-1] ? DIV_M1 - part_r[NSTG-1].rem : part_r[NSTG-1].rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[NSTG-2:0], in_valid};
      oval_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    neg_r     <= {neg_r[NSTG-2:0], in_dividend[MAG_W]};
    side_r[0] <= in_side;
    for (int s = 0; s < NSTG; s++) begin
      part_r[s] <= part_nxt[s];
    end
    for (int s = 1; s < NSTG; s++) begin
      side_r[s] <= side_r[s-1];
    end
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    oside_r <= side_r[NSTG-1];
  end

  assign out_valid     = oval_r;
  assign out_quotient  = quo_r;
  assign out_remainder = rem_r;
  assign out_side      = oside_r;

endmodule

`default_nettype wire

// File: sv/s2cal_date.sv
// Six-stage pipeline from era, day of era and second of day to the
// broken-down date and time. Uses s2cal_pkg.
`default_nettype none

module s2cal_date
  import s2cal_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [YEAR_W-1:0]  in_era,
  input  wire logic [DOE_W-1:0]   in_doe,
  input  wire logic [SOD_W-1:0]   in_sod,
  output logic                    out_valid,
  output logic signed [YEAR_W-1:0] out_year_since_1900,
  output logic [3:0]              out_month_index,
  output logic [4:0]              out_day_of_month,
  output logic [2:0]              out_weekday,
  output logic [8:0]              out_day_of_year,
  output logic [4:0]              out_hour,
  output logic [5:0]              out_minute,
  output logic [5:0]              out_second
);

  // Reciprocal constants: floor(x/d) = (x*M) >> S exactly for the ranges used.
  localparam int unsigned S_1460 = 29;
  localparam logic [47:0] M_1460 = 48'(((64'd1 << S_1460) + 64'd1459) / 64'd1460);
  localparam int unsigned S_3600 = 29;
  localparam logic [47:0] M_3600 = 48'(((64'd1 << S_3600) + 64'd3599) / 64'd3600);
  localparam int unsigned S_7 = 21;
  localparam logic [47:0] M_7 = 48'(((64'd1 << S_7) + 64'd6) / 64'd7);
  localparam int unsigned S_365 = 27;
  localparam logic [47:0] M_365 = 48'(((64'd1 << S_365) + 64'd364) / 64'd365);
  localparam int unsigned S_60 = 18;
  localparam logic [47:0] M_60 = 48'(((64'd1 << S_60) + 64'd59) / 64'd60);
  localparam int unsigned S_153 = 19;
  localparam logic [47:0] M_153 = 48'(((64'd1 << S_153) + 64'd152) / 64'd153);

  logic [CAL_STAGES-1:0] vld_r;

  // Stage 1
  logic [YEAR_W-1:0] c1_era_r;
  logic [DOE_W-1:0]  c1_doe_r, c1_doe3;
  logic [SOD_W-1:0]  c1_sod_r;
  logic [6:0]        c1_q1460_r, c1_q1460_nxt;
  logic [2:0]        c1_q36524_r, c1_q36524_nxt;
  logic [4:0]        c1_hour_r, c1_hour_nxt;
  logic [14:0]       c1_q7_r, c1_q7_nxt;
  logic [47:0]       p_1460, p_3600, p_7;

  // Stage 2
  logic [YEAR_W-1:0] c2_era_r;
  logic [DOE_W-1:0]  c2_doe_r, c2_num_r, c2_num_nxt;
  logic [11:0]       c2_remh_r, c2_remh_nxt;
  logic [4:0]        c2_hour_r;
  logic [2:0]        c2_wd_r, c2_wd_nxt;

  // Stage 3
  logic [YEAR_W-1:0] c3_era_r;
  logic [DOE_W-1:0]  c3_doe_r;
  logic [11:0]       c3_remh_r;
  logic [4:0]        c3_hour_r;
  logic [2:0]        c3_wd_r;
  logic [8:0]        c3_yoe_r, c3_yoe_nxt;
  logic [5:0]        c3_min_r, c3_min_nxt;
  logic [47:0]       p_365, p_60;

  // Stage 4
  logic [YEAR_W-1:0] c4_era_r;
  logic [8:0]        c4_yoe_r, c4_doy_r, c4_doy_nxt;
  logic [4:0]        c4_hour_r;
  logic [5:0]        c4_min_r, c4_sec_r, c4_sec_nxt;
  logic [2:0]        c4_wd_r;
  logic [1:0]        c4_c100;
  logic [DOE_W-1:0]  c4_ystart;

  // Stage 5
  logic [YEAR_W-1:0] c5_era400_r, c5_era400_nxt;
  logic [8:0]        c5_yoe_r, c5_doy_r;
  logic [4:0]        c5_hour_r;
  logic [5:0]        c5_min_r, c5_sec_r;
  logic [2:0]        c5_wd_r;
  logic [3:0]        c5_mp_r, c5_mp_nxt;
  logic [10:0]       c5_x153;
  logic [47:0]       p_153;

  // Stage 6 (outputs)
  logic              late;
  logic [8:0]        yy;
  logic              leap;
  logic [8:0]        ms;
  logic [YEAR_W-1:0] year_nxt, year_r;
  logic [3:0]        mon_nxt, mon_r;
  logic [4:0]        dom_nxt, dom_r;
  logic [8:0]        yday_nxt, yday_r;
  logic [4:0]        hour_r;
  logic [5:0]        min_r, sec_r;
  logic [2:0]        wd_r;

  always_comb begin
    c1_doe3      = in_doe + DOE_W'(3);
    p_1460       = 48'(in_doe) * M_1460;
    c1_q1460_nxt = p_1460[S_1460 +: 7];
    p_3600       = 48'(in_sod) * M_3600;
    c1_hour_nxt  = p_3600[S_3600 +: 5];
    p_7          = 48'(c1_doe3) * M_7;
    c1_q7_nxt    = p_7[S_7 +: 15];
    if (in_doe >= DOE_W'(146096))      c1_q36524_nxt = 3'd4;
    else if (in_doe >= DOE_W'(109572)) c1_q36524_nxt = 3'd3;
    else if (in_doe >= DOE_W'(73048))  c1_q36524_nxt = 3'd2;
    else if (in_doe >= DOE_W'(36524))  c1_q36524_nxt = 3'd1;
    else                               c1_q36524_nxt = 3'd0;
  end

  // The last day of an era is the only one where doe/146096 is one, which is
  // also the only one where doe/36524 reaches four.
  always_comb begin
    c2_num_nxt  = c1_doe_r - DOE_W'(c1_q1460_r) + DOE_W'(c1_q36524_r)
                - DOE_W'(c1_q36524_r[2]);
    c2_remh_nxt = 12'(c1_sod_r - SOD_W'(c1_hour_r) * SOD_W'(3600));
    c2_wd_nxt   = 3'(c1_doe_r + DOE_W'(3) - DOE_W'(c1_q7_r) * DOE_W'(7));
  end

  always_comb begin
    p_365      = 48'(c2_num_r) * M_365;
    c3_yoe_nxt = p_365[S_365 +: 9];
    p_60       = 48'(c2_remh_r) * M_60;
    c3_min_nxt = p_60[S_60 +: 6];
  end

  always_comb begin
    if (c3_yoe_r >= 9'd300)      c4_c100 = 2'd3;
    else if (c3_yoe_r >= 9'd200) c4_c100 = 2'd2;
    else if (c3_yoe_r >= 9'd100) c4_c100 = 2'd1;
    else                         c4_c100 = 2'd0;
    c4_ystart  = DOE_W'(c3_yoe_r) * DOE_W'(365) + DOE_W'(c3_yoe_r[8:2]) - DOE_W'(c4_c100);
    c4_doy_nxt = 9'(c3_doe_r - c4_ystart);
    c4_sec_nxt = 6'(c3_remh_r - 12'(c3_min_r) * 12'(60));
  end

  always_comb begin
    c5_x153       = 11'(c4_doy_r) * 11'(5) + 11'(2);
    p_153         = 48'(c5_x153) * M_153;
    c5_mp_nxt     = p_153[S_153 +: 4];
    c5_era400_nxt = c4_era_r * YEAR_W'(400);
  end

  // The era term is a multiple of 400 years, so the leap rule only needs the
  // year within the era, which runs from 0 to 400.
  always_comb begin
    late     = (c5_mp_r >= 4'd10);
    yy       = c5_yoe_r + 9'(late);
    leap     = (yy[1:0] == 2'd0) && !(yy == 9'd100 || yy == 9'd200 || yy == 9'd300);
    ms       = month_start(c5_mp_r);
    dom_nxt  = 5'(c5_doy_r - ms + 9'd1);
    mon_nxt  = late ? c5_mp_r - 4'd10 : c5_mp_r + 4'd2;
    if (late) begin
      yday_nxt = c5_doy_r - 9'd306;
    end else begin
      yday_nxt = c5_doy_r + (leap ? 9'd60 : 9'd59);
    end
    year_nxt = c5_era400_r + YEAR_W'(yy) - YEAR_W'(YEAR_BASE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CAL_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    c1_era_r    <= in_era;
    c1_doe_r    <= in_doe;
    c1_sod_r    <= in_sod;
    c1_q1460_r  <= c1_q1460_nxt;
    c1_q36524_r <= c1_q36524_nxt;
    c1_hour_r   <= c1_hour_nxt;
    c1_q7_r     <= c1_q7_nxt;

    c2_era_r    <= c1_era_r;
    c2_doe_r    <= c1_doe_r;
    c2_num_r    <= c2_num_nxt;
    c2_remh_r   <= c2_remh_nxt;
    c2_hour_r   <= c1_hour_r;
    c2_wd_r     <= c2_wd_nxt;

    c3_era_r    <= c2_era_r;
    c3_doe_r    <= c2_doe_r;
    c3_remh_r   <= c2_remh_r;
    c3_hour_r   <= c2_hour_r;
    c3_wd_r     <= c2_wd_r;
    c3_yoe_r    <= c3_yoe_nxt;
    c3_min_r    <= c3_min_nxt;

    c4_era_r    <= c3_era_r;
    c4_yoe_r    <= c3_yoe_r;
    c4_doy_r    <= c4_doy_nxt;
    c4_hour_r   <= c3_hour_r;
    c4_min_r    <= c3_min_r;
    c4_sec_r    <= c4_sec_nxt;
    c4_wd_r     <= c3_wd_r;

    c5_era400_r <= c5_era400_nxt;
    c5_yoe_r    <= c4_yoe_r;
    c5_doy_r    <= c4_doy_r;
    c5_hour_r   <= c4_hour_r;
    c5_min_r    <= c4_min_r;
    c5_sec_r    <= c4_sec_r;
    c5_wd_r     <= c4_wd_r;
    c5_mp_r     <= c5_mp_nxt;

    year_r      <= year_nxt;
    mon_r       <= mon_nxt;
    dom_r       <= dom_nxt;
    yday_r      <= yday_nxt;
    hour_r      <= c5_hour_r;
    min_r       <= c5_min_r;
    sec_r       <= c5_sec_r;
    wd_r        <= c5_wd_r;
  end

  assign out_valid           = vld_r[CAL_STAGES-1];
  assign out_year_since_1900 = year_r;
  assign out_month_index     = mon_r;
  assign out_day_of_month    = dom_r;
  assign out_weekday         = wd_r;
  assign out_day_of_year     = yday_r;
  assign out_hour            = hour_r;
  assign out_minute          = min_r;
  assign out_second          = sec_r;

endmodule

`default_nettype wire

// File: sv/seconds_to_calendar_civil.sv
// Top level of the epoch seconds to calendar converter.
// Depends on s2cal_pkg, s2cal_div and s2cal_date.
//
// Usage: present a signed count of seconds since 1970-01-01 00:00:00 UTC on
// in_epoch_seconds and raise start for one cycle; the transaction is taken
// at the rising edge where start is high and busy is low. busy never rises,
// so a new transaction can be started in every cycle.
//
// Each transaction yields one result: the proleptic Gregorian year minus
// 1900, month, day of month, weekday, day of year and time of day. The
// result is on the out_ ports for exactly one cycle, flagged by out_valid,
// and is taken at the edge that ends that cycle. The receiver cannot stall
// the block and none is needed: results leave in the order transactions
// arrived, one per cycle at most.
//
// The pipeline holds the day divider, the registered day count rebased to
// 0000-03-01, the era divider and six stages of calendar arithmetic. Both
// dividers resolve four quotient bits per stage; the rebased day count is
// W-15 bits wide with W = SECONDS_WIDTH, but at least 22. Throughput is
// one transaction per cycle.
//
// A synchronous reset (rst_n low) clears every valid bit, so transactions in
// flight are dropped and out_valid stays low until new ones arrive.
`default_nettype none

module seconds_to_calendar_civil
  import s2cal_pkg::*;
#(
  parameter int unsigned SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [SECONDS_WIDTH-1:0] in_epoch_seconds,
  output logic                          out_valid,
  output logic signed [YEAR_W-1:0]      out_year_since_1900,
  output logic [3:0]                    out_month_index,
  output logic [4:0]                    out_day_of_month,
  output logic [2:0]                    out_weekday,
  output logic [8:0]                    out_day_of_year,
  output logic [4:0]                    out_hour,
  output logic [5:0]                    out_minute,
  output logic [5:0]                    out_second
);

  // The floored day count always fits in SECONDS_WIDTH-16 bits because a
  // day is longer than 2^16 seconds.
  localparam int unsigned DAY_W = SECONDS_WIDTH - 16;
  localparam int unsigned TMP_W = tmp_width(SECONDS_WIDTH);

  logic                     acc;
  logic                     d1_valid;
  logic [SECONDS_WIDTH-1:0] d1_quo;
  logic [SOD_W-1:0]         d1_sod;
  logic signed [DAY_W-1:0]  days;

  logic                     sh_vld_r;
  logic [TMP_W-1:0]         sh_tmp_r, sh_tmp_nxt;
  logic [SOD_W-1:0]         sh_sod_r;

  logic                     d2_valid;
  logic signed [TMP_W-1:0]  d2_era;
  logic [DOE_W-1:0]         d2_doe;
  logic [SOD_W-1:0]         d2_sod;
  logic [YEAR_W-1:0]        era_lo;

  // The pipeline never holds off a transaction.
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // Seconds split into whole days (floored) and the second of the day.
  s2cal_div #(
    .DIVIDEND_W (SECONDS_WIDTH),
    .DIVISOR    (SECS_PER_DAY),
    .REM_W      (SOD_W),
    .SIDE_W     (1)
  ) u_day_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (acc),
    .in_dividend   (in_epoch_seconds),
    .in_side       (1'b0),
    .out_valid     (d1_valid),
    .out_quotient  (d1_quo),
    .out_remainder (d1_sod),
    .out_side      ()
  );

  // Rebase the day count to 0000-03-01 so that eras start on a March 1.
  assign days       = d1_quo[DAY_W-1:0];
  assign sh_tmp_nxt = TMP_W'(days) + TMP_W'(EPOCH_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_vld_r <= 1'b0;
    end else begin
      sh_vld_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    sh_tmp_r <= sh_tmp_nxt;
    sh_sod_r <= d1_sod;
  end

  // Split into 400-year eras and the day of the era. An era is a whole
  // number of weeks, so the weekday follows from the day of the era alone.
  s2cal_div #(
    .DIVIDEND_W (TMP_W),
    .DIVISOR    (ERA_DAYS),
    .REM_W      (DOE_W),
    .SIDE_W     (SOD_W)
  ) u_era_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sh_vld_r),
    .in_dividend   (sh_tmp_r),
    .in_side       (sh_sod_r),
    .out_valid     (d2_valid),
    .out_quotient  (d2_era),
    .out_remainder (d2_doe),
    .out_side      (d2_sod)
  );

  // Only the low bits of the era matter: the year output wraps at 24 bits.
  assign era_lo = YEAR_W'(d2_era);

  s2cal_date u_date (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (d2_valid),
    .in_era              (era_lo),
    .in_doe              (d2_doe),
    .in_sod              (d2_sod),
    .out_valid           (out_valid),
    .out_year_since_1900 (out_year_since_1900),
    .out_month_index     (out_month_index),
    .out_day_of_month    (out_day_of_month),
    .out_weekday         (out_weekday),
    .out_day_of_year     (out_day_of_year),
    .out_hour            (out_hour),
    .out_minute          (out_minute),
    .out_second          (out_second)
  );

endmodule

`default_nettype wire

// File: sv/s2cal_chk.sv
// Port-level checker for the epoch seconds to calendar converter, bound to
// the top level. Uses s2cal_pkg.
`default_nettype none

module s2cal_chk
  import s2cal_pkg::*;
#(
  parameter int unsigned SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [3:0] out_month_index,
  input wire logic [4:0] out_day_of_month,
  input wire logic [2:0] out_weekday,
  input wire logic [8:0] out_day_of_year,
  input wire logic [4:0] out_hour,
  input wire logic [5:0] out_minute,
  input wire logic [5:0] out_second
);

  localparam int unsigned LAT = pipe_latency(SECONDS_WIDTH);

  // Every accepted transaction produces its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after an accepted transaction");

  // No result without a transaction accepted exactly one latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_index <= 4'd11) && (out_day_of_month >= 5'd1)
                  && (out_weekday <= 3'd6) && (out_day_of_year <= 9'd365))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59))
    else $error("time field out of range");

endmodule

bind seconds_to_calendar_civil s2cal_chk #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_s2cal_chk (.*);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for seconds_to_calendar_civil: epoch seconds in, civil date out.
// Depends on s2cal_pkg and the converter RTL; carries its own calendar predictor.

module tb_top;
  import s2cal_pkg::*;

  localparam int unsigned SW = SECONDS_WIDTH_DEF;

  // The drain and the watchdog are sized well above the pipeline depth.
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  // The last stretch of transactions goes in back to back, with no gaps.
  localparam int QUIET_TAIL     = 200;
  localparam int RANDOM_ITEMS   = 1630;
  // Past this many reports the errors are only counted, so a badly broken
  // design does not flood the log.
  localparam int MAX_REPORTS    = 40;

  localparam longint MAX_SEC = (longint'(1) << (SW - 1)) - 1;
  localparam longint MIN_SEC = -(longint'(1) << (SW - 1));

  // One broken-down civil date, laid out at the widths of the result ports.
  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [3:0]               month;
    logic [4:0]               mday;
    logic [2:0]               wday;
    logic [8:0]               yday;
    logic [4:0]               hour;
    logic [5:0]               minute;
    logic [5:0]               second;
  } civil_date_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [SW-1:0] in_epoch_seconds = '0;
  logic          busy;
  logic          out_valid;
  logic signed [YEAR_W-1:0] out_year_since_1900;
  logic [3:0]    out_month_index;
  logic [4:0]    out_day_of_month;
  logic [2:0]    out_weekday;
  logic [8:0]    out_day_of_year;
  logic [4:0]    out_hour;
  logic [5:0]    out_minute;
  logic [5:0]    out_second;

  // Timestamps waiting to be offered, and the dates predicted for the
  // transactions already taken, oldest first.
  logic [SW-1:0] epoch_stimulus[$];
  civil_date_t   pending_dates[$];

  int total_items    = 0;
  int accepted_items = 0;
  int result_count   = 0;
  int error_count    = 0;
  int gap_left       = 0;
  int idle_cycles    = 0;

  seconds_to_calendar_civil #(
    .SECONDS_WIDTH(SW)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_epoch_seconds   (in_epoch_seconds),
    .out_valid          (out_valid),
    .out_year_since_1900(out_year_since_1900),
    .out_month_index    (out_month_index),
    .out_day_of_month   (out_day_of_month),
    .out_weekday        (out_weekday),
    .out_day_of_year    (out_day_of_year),
    .out_hour           (out_hour),
    .out_minute         (out_minute),
    .out_second         (out_second)
  );

  always #5 clk = ~clk;

  // Division that rounds toward minus infinity; the remainder is never
  // negative for a positive divisor.
  function automatic longint floor_div_rem(input longint num, input longint den,
                                           output longint rem);
    longint q;
    q   = num / den;
    rem = num % den;
    if (rem < 0) begin
      rem += den;
      q--;
    end
    return q;
  endfunction

  // Predicts the civil date of an epoch timestamp. Days and seconds of the
  // day come from floor division, so instants before 1970 land on the day
  // that holds them. The date uses the March-based 400-year era split: a
  // day count from 0000-03-01 is cut into eras, a year of the era, a day
  // of the March year and a month.
  function automatic civil_date_t civil_from_epoch(input logic [SW-1:0] raw);
    civil_date_t d;
    longint secs, days, sod, wd, era, doe, yoe, doy, mp, mon, yr, yd;
    bit     leap;
    secs = longint'($signed(raw));
    days = floor_div_rem(secs, longint'(SECS_PER_DAY), sod);
    // 1970-01-01 was a Thursday, four days after a Sunday.
    void'(floor_div_rem(days + 4, 7, wd));
    era  = floor_div_rem(days + longint'(EPOCH_SHIFT), longint'(ERA_DAYS), doe);
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    // January and February belong to the next civil year.
    yr   = yoe + era * 400 + ((mp >= 10) ? 1 : 0);
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    yd   = (mp < 10) ? doy + (leap ? 60 : 59) : doy - 306;
    d.year   = YEAR_W'(yr - longint'(YEAR_BASE));
    d.month  = 4'(mon - 1);
    d.mday   = 5'(doy - (153 * mp + 2) / 5 + 1);
    d.wday   = 3'(wd);
    d.yday   = 9'(yd);
    d.hour   = 5'(sod / 3600);
    d.minute = 6'((sod / 60) % 60);
    d.second = 6'(sod % 60);
    return d;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR: t=%0t result %0d %s: got %0d, want %0d",
               $time, result_count, what, got, want);
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic add_seconds(input longint secs);
    epoch_stimulus.push_back(SW'(secs));
  endtask

  // Driver. A transaction is taken at an edge where start is high and busy
  // is low. Each signal gets at most one nonblocking assignment per edge, so
  // start stays high across back-to-back transactions.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left =  0;
    end else begin
      if (start && !busy) begin
        pending_dates.push_back(civil_from_epoch(in_epoch_seconds));
        accepted_items++;
      end
      if (start && busy) begin
        // Not taken yet: hold the same timestamp.
        start <= 1'b1;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (epoch_stimulus.size() > 0) begin
        in_epoch_seconds <= epoch_stimulus.pop_front();
        start            <= 1'b1;
        // Random idle bursts, except in the closing stretch.
        if (epoch_stimulus.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
          gap_left = $urandom_range(1, 9);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. A result is valid for one cycle only and cannot be stalled,
  // so it is compared at the edge that ends that cycle.
  always @(posedge clk) begin : result_check
    civil_date_t want;
    if (rst_n && out_valid) begin
      result_count++;
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result, year", longint'(out_year_since_1900), 0);
      end else begin
        want = pending_dates.pop_front();
        check_field("year_since_1900", longint'(out_year_since_1900), longint'(want.year));
        check_field("month_index", out_month_index, want.month);
        check_field("day_of_month", out_day_of_month, want.mday);
        check_field("weekday", out_weekday, want.wday);
        check_field("day_of_year", out_day_of_year, want.yday);
        check_field("hour", out_hour, want.hour);
        check_field("minute", out_minute, want.minute);
        check_field("second", out_second, want.second);
      end
    end
  end

  // Watchdog: too many edges in a row with no transaction in or out means
  // the design has hung.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog expired, nothing moved for %0d cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit [31:0] r_hi;
    bit [31:0] r_lo;
    longint    x;
    longint    days;
    longint    era_idx;
    longint    doe;
    int        k;

    // Directed timestamps: the epoch and the seconds around it, both ends of
    // the input range, leap days and century rules, era boundaries and the
    // day before the last day of a leap year.
    add_seconds(0);
    add_seconds(-1);               // 1969-12-31 23:59:59, floored day
    add_seconds(59);
    add_seconds(3599);
    add_seconds(43200);
    add_seconds(86399);
    add_seconds(86400);
    add_seconds(-86400);
    add_seconds(-86401);
    add_seconds(MAX_SEC);
    add_seconds(MIN_SEC);
    add_seconds(951782400);        // 2000-02-29, leap century
    add_seconds(951868800);        // 2000-03-01
    add_seconds(-2203891200);      // 1900-03-01, century without a leap day
    add_seconds(4107542399);       // 2100-02-28 23:59:59
    add_seconds(946684799);        // 1999-12-31 23:59:59
    add_seconds(978220799);        // 2000-12-30, day 364 of a leap year
    add_seconds(-62162035200);     // 0000-03-01, start of an era
    add_seconds(-62162035201);     // last second of 0000-02-29
    add_seconds(-62135596800);     // 0001-01-01
    add_seconds(253402300799);     // 9999-12-31 23:59:59
    add_seconds(2147483647);
    add_seconds(-2147483648);

    // Random timestamps, mixed between the whole range, the centuries around
    // today, day boundaries, era corner days, the range ends and values near powers of two.
    repeat (RANDOM_ITEMS) begin
      r_hi = $urandom;
      r_lo = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          epoch_stimulus.push_back({r_hi[15:0], r_lo});
        end
        3, 4: begin
          epoch_stimulus.push_back(SW'({{29{r_hi[2]}}, r_hi[2:0], r_lo}));
        end
        5, 6: begin
          days = longint'($urandom_range(0, 32'd1 << 26)) - (longint'(1) << 25);
          x    = days * longint'(SECS_PER_DAY);
          case (r_lo[1:0])
            2'd0: x = x - 1;
            2'd1: x = x + 1;
            2'd2: x = x + longint'(SECS_PER_DAY) - 1;
            default: ;
          endcase
          add_seconds(x);
        end
        7: begin
          // Days of the era where the leap corrections of the year split
          // change value.
          era_idx = longint'($urandom_range(0, 60)) - 30;
          case ($urandom_range(0, 11))
            0:  doe = 0;
            1:  doe = 305;
            2:  doe = 306;
            3:  doe = 364;
            4:  doe = 365;
            5:  doe = 1459;
            6:  doe = 1460;
            7:  doe = 36523;
            8:  doe = 36524;
            9:  doe = 146095;
            10: doe = 146096;
            default: doe = longint'($urandom_range(0, ERA_DAYS - 1));
          endcase
          days = era_idx * longint'(ERA_DAYS) + doe - longint'(EPOCH_SHIFT);
          add_seconds(days * longint'(SECS_PER_DAY) +
                      longint'($urandom_range(0, SECS_PER_DAY - 1)));
        end
        8: begin
          x = longint'($urandom_range(0, 200000));
          add_seconds(r_lo[0] ? MAX_SEC - x : MIN_SEC + x);
        end
        default: begin
          k = $urandom_range(0, SW - 2);
          x = (longint'(1) << k) + longint'($urandom_range(0, 4)) - 2;
          add_seconds(r_lo[0] ? -x : x);
        end
      endcase
    end
    total_items = epoch_stimulus.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_items) @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
    // Keep watching for a while so a stray extra result is caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
